### hw/rtl/nearest_strain_read_classifier_core_macros.svh
// Assertion macros used by the strain classifier core
`ifndef NEAREST_STRAIN_READ_CLASSIFIER_CORE_MACROS_SVH
`define NEAREST_STRAIN_READ_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define NSRC_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define NSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSRC_ASSERT_NOW(lbl, cond, msg)
`define NSRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/nsrc_pkg.sv
// Types, constants and helper functions for the strain classifier
package nsrc_pkg;

    localparam int ACC_W  = 9;
    localparam int CNT_W  = 32;
    localparam int CHAR_W = 8;

    typedef logic [ACC_W-1:0]  t_acc;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CHAR_W-1:0] t_char;

    localparam t_acc  ACC_MAX    = '1;
    localparam t_cnt  CNT_MAX    = '1;
    localparam t_acc  DIST_LIMIT = 9'd2;

    localparam t_char CHAR_A = 8'h41;
    localparam t_char CHAR_C = 8'h43;
    localparam t_char CHAR_G = 8'h47;
    localparam t_char CHAR_T = 8'h54;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_STRAIN_COUNT = 2'd0,
        CFG_MIN_VALID    = 2'd1,
        CFG_MAX_MISMATCH = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MIN,
        S_CNT_RD,
        S_EMIT
    } t_state;

    // control from the sequencer to the distance accumulators
    typedef struct packed {
        logic valid_inc;
        logic cmp;
        logic min_en;
        logic min_first;
        logic clr;
    } t_acc_ctl;

    // control from the sequencer to the strain counter store
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_cnt_ctl;

    function automatic logic is_acgt(input t_char c);
        return (c == CHAR_A) || (c == CHAR_C) || (c == CHAR_G) || (c == CHAR_T);
    endfunction

    function automatic t_acc sat_acc(input t_acc v);
        return (v == ACC_MAX) ? v : v + t_acc'(1);
    endfunction

    function automatic t_cnt sat_cnt(input t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

endpackage

### hw/rtl/nsrc_ref_store.sv
// Reference base memory: one byte per strain and locus, one write and one read port
module nsrc_ref_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  nsrc_pkg::t_char       i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output nsrc_pkg::t_char       o_rdata
);

    nsrc_pkg::t_char r_mem [DEPTH];
    nsrc_pkg::t_char r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/nsrc_count_store.sv
// Per-strain raw and consensus counters in a memory, with valid bits for fast clear
module nsrc_count_store #(
    parameter int MAX_STRAINS = 8,
    parameter int SW          = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nsrc_pkg::t_cnt_ctl   i_ctl,
    input  logic [SW-1:0]        i_idx,
    input  nsrc_pkg::t_cnt       i_raw,
    input  nsrc_pkg::t_cnt       i_cons,
    output nsrc_pkg::t_cnt       o_raw,
    output nsrc_pkg::t_cnt       o_cons
);

    localparam int DW = 2 * nsrc_pkg::CNT_W;

    logic [DW-1:0]          r_mem [MAX_STRAINS];
    logic [MAX_STRAINS-1:0] r_vld;
    logic [DW-1:0]          r_rd_data;
    logic                   r_rd_ok;

    // entries not written since the last clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clr) begin
            r_vld <= '0;
        end else if (i_ctl.wr) begin
            r_vld[i_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_idx] <= {i_raw, i_cons};
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_idx];
            r_rd_ok   <= r_vld[i_idx];
        end
    end

    assign o_raw  = r_rd_ok ? r_rd_data[DW-1:nsrc_pkg::CNT_W] : '0;
    assign o_cons = r_rd_ok ? r_rd_data[nsrc_pkg::CNT_W-1:0]  : '0;

endmodule

### hw/rtl/nsrc_dist_acc.sv
// Mismatch and valid-base accumulators with a serial minimum search
module nsrc_dist_acc #(
    parameter int MAX_STRAINS = 8,
    parameter int SW          = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nsrc_pkg::t_acc_ctl   i_ctl,
    input  logic [SW-1:0]        i_idx,
    input  nsrc_pkg::t_char      i_ref_byte,
    input  nsrc_pkg::t_char      i_base,
    output nsrc_pkg::t_acc       o_valid_cnt,
    output nsrc_pkg::t_acc       o_best,
    output logic [SW-1:0]        o_win
);

    nsrc_pkg::t_acc r_mis [MAX_STRAINS];
    nsrc_pkg::t_acc r_valid_cnt;
    nsrc_pkg::t_acc r_best;
    logic [SW-1:0]  r_win;
    nsrc_pkg::t_acc cur;
    logic           mismatch;

    assign cur      = r_mis[i_idx];
    assign mismatch = (i_ref_byte != i_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_STRAINS; s++) begin
                r_mis[s] <= '0;
            end
            r_valid_cnt <= '0;
        end else if (i_ctl.clr) begin
            for (int s = 0; s < MAX_STRAINS; s++) begin
                r_mis[s] <= '0;
            end
            r_valid_cnt <= '0;
        end else begin
            if (i_ctl.cmp && mismatch) begin
                r_mis[i_idx] <= nsrc_pkg::sat_acc(cur);
            end
            if (i_ctl.valid_inc) begin
                r_valid_cnt <= nsrc_pkg::sat_acc(r_valid_cnt);
            end
        end
    end

    // strict less-than keeps the lowest strain on ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.min_en && (i_ctl.min_first || (cur < r_best))) begin
            r_best <= cur;
            r_win  <= i_idx;
        end
    end

    assign o_valid_cnt = r_valid_cnt;
    assign o_best      = r_best;
    assign o_win       = r_win;

endmodule

### hw/rtl/nearest_strain_read_classifier_core.sv
// Read base: one reference memory read per strain in the scan, plus a drain step.
// Last base of a read adds a minimum search over at most MAX_STRAINS strains, one
// counter memory read and an emit step that waits while the output word is held.
// Load and clear words finish when taken; a query reads the counters, then emits.
// Synchronous active-low reset clears accumulators, counters and control, loads config
// defaults; the reference memory is not cleared and holds garbage until loaded.
`include "nearest_strain_read_classifier_core_macros.svh"

module nearest_strain_read_classifier_core #(
    parameter int MAX_STRAINS = 8,
    parameter int MAX_LOCI    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_strain_sel,
    input  logic [7:0]  i_locus_index,
    input  logic [7:0]  i_base_char,
    input  logic        i_is_consensus,
    input  logic        i_last_base,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_report_kind,
    output logic        o_assigned,
    output logic [2:0]  o_winner,
    output logic        o_enough_valid,
    output logic [8:0]  o_min_distance,
    output logic [31:0] o_raw_total,
    output logic [31:0] o_consensus_total,
    output logic [31:0] o_attempt_total
);

    localparam int SW    = (MAX_STRAINS > 1) ? $clog2(MAX_STRAINS) : 1;
    localparam int CW    = $clog2(MAX_STRAINS + 1);
    localparam int DEPTH = MAX_STRAINS * MAX_LOCI;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    nsrc_pkg::t_state  r_state, n_state;
    nsrc_pkg::t_opcode r_op;
    logic [2:0]        r_sel;
    logic              r_sel_ok;
    logic [7:0]        r_locus;
    nsrc_pkg::t_char   r_char;
    logic              r_cons;
    logic              r_last;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_cmp_vld;
    logic [SW-1:0]     r_cmp_idx;
    nsrc_pkg::t_cnt    r_attempt;

    logic [3:0]        r_cfg_count;
    nsrc_pkg::t_acc    r_cfg_min_valid;
    nsrc_pkg::t_acc    r_cfg_max_mis;

    logic              r_out_valid;
    logic              r_out_kind;
    logic              r_out_assigned;
    logic [2:0]        r_out_winner;
    logic              r_out_enough;
    nsrc_pkg::t_acc    r_out_min;
    nsrc_pkg::t_cnt    r_out_raw;
    nsrc_pkg::t_cnt    r_out_cons;
    nsrc_pkg::t_cnt    r_out_attempt;

    nsrc_pkg::t_opcode in_op;
    logic              in_acc;
    logic              in_sel_ok;
    logic              in_loc_ok;
    logic              in_base_ok;

    logic              ref_we;
    logic [AW-1:0]     ref_waddr;
    logic              ref_re;
    logic [AW-1:0]     ref_raddr;
    nsrc_pkg::t_char   ref_rdata;

    nsrc_pkg::t_acc_ctl acc_ctl;
    logic [SW-1:0]      acc_idx;
    nsrc_pkg::t_acc     valid_cnt;
    nsrc_pkg::t_acc     best;
    logic [SW-1:0]      win;

    nsrc_pkg::t_cnt_ctl cnt_ctl;
    logic [SW-1:0]      cnt_idx;
    nsrc_pkg::t_cnt     cnt_raw;
    nsrc_pkg::t_cnt     cnt_cons;

    logic [CW-1:0]     k;
    logic              enough;
    logic              search_ok;
    logic              assigned;
    nsrc_pkg::t_acc    best_out;
    nsrc_pkg::t_cnt    raw_new;
    nsrc_pkg::t_cnt    cons_new;
    nsrc_pkg::t_cnt    attempt_new;
    logic              out_free;
    logic              emit_fire;

    // ---------------------------------------------------------------
    // input word decode
    assign in_op      = nsrc_pkg::t_opcode'(i_opcode);
    assign o_in_ready = (r_state == nsrc_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_sel_ok  = (32'(i_strain_sel) < 32'(MAX_STRAINS));
    assign in_loc_ok  = (32'(i_locus_index) < 32'(MAX_LOCI));
    assign in_base_ok = in_loc_ok && nsrc_pkg::is_acgt(i_base_char);

    // ---------------------------------------------------------------
    // decision terms
    assign k = (32'(r_cfg_count) > 32'(MAX_STRAINS)) ? CW'(MAX_STRAINS) : CW'(r_cfg_count);
    assign enough    = (valid_cnt >= r_cfg_min_valid);
    assign search_ok = enough && (k != '0);
    assign best_out  = search_ok ? best : '0;
    assign assigned  = search_ok && (best < nsrc_pkg::DIST_LIMIT) && (best <= r_cfg_max_mis);

    assign raw_new     = r_cons ? cnt_raw : nsrc_pkg::sat_cnt(cnt_raw);
    assign cons_new    = r_cons ? nsrc_pkg::sat_cnt(cnt_cons) : cnt_cons;
    assign attempt_new = r_cons ? nsrc_pkg::sat_cnt(r_attempt) : r_attempt;

    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_fire = (r_state == nsrc_pkg::S_EMIT) && out_free;

    // ---------------------------------------------------------------
    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nsrc_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        nsrc_pkg::OP_READ: begin
                            if (in_base_ok) begin
                                n_state = nsrc_pkg::S_SCAN;
                            end else if (i_last_base) begin
                                n_state = nsrc_pkg::S_MIN;
                            end
                        end
                        nsrc_pkg::OP_QUERY: n_state = nsrc_pkg::S_CNT_RD;
                        default:            n_state = nsrc_pkg::S_IDLE;
                    endcase
                end
            end
            nsrc_pkg::S_SCAN: begin
                // the drain step at r_idx == MAX_STRAINS lets the last compare land
                if (r_idx == CW'(MAX_STRAINS)) begin
                    n_state = r_last ? nsrc_pkg::S_MIN : nsrc_pkg::S_IDLE;
                end
            end
            nsrc_pkg::S_MIN: begin
                if (!search_ok || ((r_idx + CW'(1)) == k)) begin
                    n_state = nsrc_pkg::S_CNT_RD;
                end
            end
            nsrc_pkg::S_CNT_RD: n_state = nsrc_pkg::S_EMIT;
            nsrc_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = nsrc_pkg::S_IDLE;
                end
            end
            default: n_state = nsrc_pkg::S_IDLE;
        endcase
    end

    // strain index for scan and minimum search
    always_comb begin
        n_idx = '0;
        unique case (r_state)
            nsrc_pkg::S_SCAN: n_idx = (r_idx == CW'(MAX_STRAINS)) ? '0 : r_idx + CW'(1);
            nsrc_pkg::S_MIN:  n_idx = r_idx + CW'(1);
            default:          n_idx = '0;
        endcase
    end

    // sequencer: outputs to the memories and accumulators
    always_comb begin
        ref_we    = in_acc && (in_op == nsrc_pkg::OP_LOAD) && in_sel_ok && in_loc_ok;
        ref_waddr = AW'(AW'(i_strain_sel) * AW'(MAX_LOCI)) + AW'(i_locus_index);
        ref_re    = (r_state == nsrc_pkg::S_SCAN) && (r_idx != CW'(MAX_STRAINS));
        ref_raddr = AW'(AW'(r_idx[SW-1:0]) * AW'(MAX_LOCI)) + AW'(r_locus);

        acc_ctl.valid_inc = in_acc && (in_op == nsrc_pkg::OP_READ) && in_base_ok;
        acc_ctl.cmp       = r_cmp_vld;
        acc_ctl.min_en    = (r_state == nsrc_pkg::S_MIN) && search_ok;
        acc_ctl.min_first = (r_idx == '0);
        acc_ctl.clr       = emit_fire && (r_op == nsrc_pkg::OP_READ);
        acc_idx           = r_cmp_vld ? r_cmp_idx : r_idx[SW-1:0];

        cnt_ctl.rd  = (r_state == nsrc_pkg::S_CNT_RD);
        cnt_ctl.wr  = emit_fire && (r_op == nsrc_pkg::OP_READ) && assigned;
        cnt_ctl.clr = in_acc && (in_op == nsrc_pkg::OP_CLEAR);
        cnt_idx     = (r_op == nsrc_pkg::OP_QUERY) ? SW'(r_sel) : win;
    end

    // ---------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nsrc_pkg::S_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_attempt <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= ref_re;
            if (cnt_ctl.clr) begin
                r_attempt <= '0;
            end else if (emit_fire && (r_op == nsrc_pkg::OP_READ)) begin
                r_attempt <= attempt_new;
            end
        end
    end

    // latched input word
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx[SW-1:0];
        if (in_acc) begin
            r_op     <= in_op;
            r_sel    <= i_strain_sel;
            r_sel_ok <= in_sel_ok;
            r_locus  <= i_locus_index;
            r_char   <= i_base_char;
            r_cons   <= i_is_consensus;
            r_last   <= i_last_base;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count     <= 4'd1;
            r_cfg_min_valid <= '0;
            r_cfg_max_mis   <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (nsrc_pkg::t_cfg_index'(i_cfg_index))
                nsrc_pkg::CFG_STRAIN_COUNT: r_cfg_count     <= i_cfg_wdata[3:0];
                nsrc_pkg::CFG_MIN_VALID:    r_cfg_min_valid <= i_cfg_wdata;
                nsrc_pkg::CFG_MAX_MISMATCH: r_cfg_max_mis   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // output register: a held word blocks new input words only once the next report waits to emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            if (r_op == nsrc_pkg::OP_QUERY) begin
                r_out_kind     <= 1'b1;
                r_out_assigned <= 1'b0;
                r_out_winner   <= r_sel;
                r_out_enough   <= 1'b0;
                r_out_min      <= '0;
                r_out_raw      <= r_sel_ok ? cnt_raw : '0;
                r_out_cons     <= r_sel_ok ? cnt_cons : '0;
                r_out_attempt  <= r_attempt;
            end else begin
                r_out_kind     <= 1'b0;
                r_out_assigned <= assigned;
                r_out_winner   <= assigned ? 3'(win) : 3'd0;
                r_out_enough   <= enough;
                r_out_min      <= best_out;
                r_out_raw      <= assigned ? raw_new : '0;
                r_out_cons     <= assigned ? cons_new : '0;
                r_out_attempt  <= attempt_new;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_report_kind     = r_out_kind;
    assign o_assigned        = r_out_assigned;
    assign o_winner          = r_out_winner;
    assign o_enough_valid    = r_out_enough;
    assign o_min_distance    = r_out_min;
    assign o_raw_total       = r_out_raw;
    assign o_consensus_total = r_out_cons;
    assign o_attempt_total   = r_out_attempt;

    // ---------------------------------------------------------------
    nsrc_ref_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ref_store (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (i_base_char),
        .i_re    (ref_re),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    nsrc_dist_acc #(
        .MAX_STRAINS (MAX_STRAINS),
        .SW          (SW)
    ) u_dist_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_idx       (acc_idx),
        .i_ref_byte  (ref_rdata),
        .i_base      (r_char),
        .o_valid_cnt (valid_cnt),
        .o_best      (best),
        .o_win       (win)
    );

    nsrc_count_store #(
        .MAX_STRAINS (MAX_STRAINS),
        .SW          (SW)
    ) u_count_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_idx   (cnt_idx),
        .i_raw   (raw_new),
        .i_cons  (cons_new),
        .o_raw   (cnt_raw),
        .o_cons  (cnt_cons)
    );

    // ---------------------------------------------------------------
    `NSRC_ASSERT_NOW(a_cnt_wr_emit, !cnt_ctl.wr || ((r_state == nsrc_pkg::S_EMIT) && (r_op == nsrc_pkg::OP_READ)), "counter write outside a read decision")
    `NSRC_ASSERT_NOW(a_min_after_drain, !(r_cmp_vld && (r_state == nsrc_pkg::S_MIN)), "minimum search overlaps a pending compare")
    `NSRC_ASSERT_NEXT(a_scan_blocks, in_acc && (in_op == nsrc_pkg::OP_READ) && in_base_ok, !o_in_ready, "input taken during strain scan")

endmodule
